// ===== rtl/core/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, register map and constants of the antenna tuning sweep.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

  localparam int CAP_CODES_DEF = 16;

  localparam int EDGE_W = 20;
  localparam int TICK_W = 24;
  localparam int CAP_W  = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // reset values of the configuration registers
  localparam logic [EDGE_W-1:0] TARGET_RST = EDGE_W'(3125);
  localparam logic [TICK_W-1:0] SETTLE_RST = TICK_W'(10000);
  localparam logic [TICK_W-1:0] WINDOW_RST = TICK_W'(100000);
  localparam logic [EDGE_W-1:0] LIMIT_RST  = EDGE_W'(10000);

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_SETTLE = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  // sweep phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_COUNT  = 2'd2;

  typedef struct packed {
    logic [EDGE_W-1:0] target_edges;
    logic [TICK_W-1:0] settle_ticks;
    logic [TICK_W-1:0] window_ticks;
    logic [EDGE_W-1:0] start_limit;
  } ats_cfg_t;

  typedef struct packed {
    logic [CAP_W-1:0]  cap_drive;
    logic              show_oscillator;
    logic              busy_res;
    logic              done_res;
    logic [CAP_W-1:0]  chosen_cap;
    logic [EDGE_W-1:0] last_edges;
  } ats_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ats_regs.sv =====
// ----------------------------------------------------------------------------
// ats_regs
// APB-style configuration registers of the tuning sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ats_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ats_pkg::DATA_W-1:0] pwdata,
  output logic      [ats_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output ats_pkg::ats_cfg_t               cfg
);
  import ats_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_edges <= TARGET_RST;
      cfg.settle_ticks <= SETTLE_RST;
      cfg.window_ticks <= WINDOW_RST;
      cfg.start_limit  <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET: cfg.target_edges <= pwdata[EDGE_W-1:0];
        REG_SETTLE: cfg.settle_ticks <= pwdata[TICK_W-1:0];
        REG_WINDOW: cfg.window_ticks <= pwdata[TICK_W-1:0];
        REG_LIMIT:  cfg.start_limit  <= pwdata[EDGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET: prdata = DATA_W'(cfg.target_edges);
      REG_SETTLE: prdata = DATA_W'(cfg.settle_ticks);
      REG_WINDOW: prdata = DATA_W'(cfg.window_ticks);
      REG_LIMIT:  prdata = DATA_W'(cfg.start_limit);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ats_sweep.sv =====
// ----------------------------------------------------------------------------
// ats_sweep
// Sweep sequencer: settle, count and rank codes per tick while they improve.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_sweep #(
  parameter int CAP_CODES = ats_pkg::CAP_CODES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic                  start_req,
  input  wire logic                  lco_edge,
  input  wire ats_pkg::ats_cfg_t     cfg,
  output ats_pkg::ats_result_t       result
);
  import ats_pkg::*;

  localparam int CODE_W = $clog2(CAP_CODES);
  localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(CAP_CODES - 1);

  logic [1:0]        phase, phase_next;
  logic [CODE_W-1:0] code_index, code_index_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [EDGE_W-1:0] edge_count, edge_count_next;
  logic [EDGE_W-1:0] best_difference, best_difference_next;
  logic [CODE_W-1:0] best_code, best_code_next;
  logic [CODE_W-1:0] applied_cap, applied_cap_next;
  logic [CODE_W-1:0] chosen_code, chosen_code_next;
  logic [EDGE_W-1:0] window_result, window_result_next;

  logic [TICK_W-1:0] tick_inc;
  logic [EDGE_W-1:0] edge_inc;
  logic [TICK_W-1:0] window_len;
  logic [EDGE_W-1:0] diff;
  logic              finish;
  logic              done;

  logic [CODE_W+CAP_W-1:0] applied_ext;
  logic [CODE_W+CAP_W-1:0] chosen_ext;

  // saturating counters
  assign tick_inc   = (tick_count != TICK_MAX) ? tick_count + TICK_W'(1) : tick_count;
  assign edge_inc   = (lco_edge && edge_count != EDGE_MAX) ? edge_count + EDGE_W'(1)
                                                           : edge_count;
  assign window_len = (cfg.window_ticks == '0) ? TICK_W'(1) : cfg.window_ticks;
  assign diff       = (edge_inc >= cfg.target_edges) ? edge_inc - cfg.target_edges
                                                     : cfg.target_edges - edge_inc;

  always_comb begin
    phase_next           = phase;
    code_index_next      = code_index;
    tick_count_next      = tick_count;
    edge_count_next      = edge_count;
    best_difference_next = best_difference;
    best_code_next       = best_code;
    applied_cap_next     = applied_cap;
    chosen_code_next     = chosen_code;
    window_result_next   = window_result;
    finish               = 1'b0;
    done                 = 1'b0;
    unique case (phase)
      PH_SETTLE: begin
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.settle_ticks) begin
          phase_next      = PH_COUNT;
          tick_count_next = '0;
          edge_count_next = '0;
        end
      end
      PH_COUNT: begin
        edge_count_next = edge_inc;
        tick_count_next = tick_inc;
        if (tick_inc >= window_len) begin
          window_result_next = edge_inc;
          finish             = 1'b1;
          if (diff < best_difference) begin
            best_difference_next = diff;
            best_code_next       = code_index;
            if (code_index != LAST_CODE) begin
              code_index_next  = code_index + CODE_W'(1);
              applied_cap_next = code_index + CODE_W'(1);
              phase_next       = PH_SETTLE;
              tick_count_next  = '0;
              finish           = 1'b0;
            end
          end
          if (finish) begin
            phase_next       = PH_IDLE;
            chosen_code_next = best_code_next;
            applied_cap_next = best_code_next;
            done             = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          phase_next           = PH_SETTLE;
          code_index_next      = '0;
          tick_count_next      = '0;
          edge_count_next      = '0;
          best_difference_next = cfg.start_limit;
          best_code_next       = '0;
          applied_cap_next     = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      code_index      <= '0;
      tick_count      <= '0;
      edge_count      <= '0;
      best_difference <= LIMIT_RST;
      best_code       <= '0;
      applied_cap     <= '0;
      chosen_code     <= '0;
      window_result   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      code_index      <= code_index_next;
      tick_count      <= tick_count_next;
      edge_count      <= edge_count_next;
      best_difference <= best_difference_next;
      best_code       <= best_code_next;
      applied_cap     <= applied_cap_next;
      chosen_code     <= chosen_code_next;
      window_result   <= window_result_next;
    end
  end

  // codes show their low four bits
  assign applied_ext = {{CAP_W{1'b0}}, applied_cap_next};
  assign chosen_ext  = {{CAP_W{1'b0}}, chosen_code_next};

  always_comb begin
    result.cap_drive       = applied_ext[CAP_W-1:0];
    result.show_oscillator = (phase_next != PH_IDLE);
    result.busy_res        = (phase_next != PH_IDLE);
    result.done_res        = done;
    result.chosen_cap      = chosen_ext[CAP_W-1:0];
    result.last_edges      = window_result_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ats_out_buf.sv =====
// ----------------------------------------------------------------------------
// ats_out_buf
// Result register with a skid stage between the tick and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ats_pkg::ats_result_t push_data,
  output logic                      space,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ats_pkg::ats_result_t      out_data
);
  import ats_pkg::*;

  ats_result_t skid_data;
  logic        skid_valid;
  logic        pop;

  assign space = ~skid_valid;
  assign pop   = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (push) begin
      skid_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/antenna_tuning_sweep.sv =====
// ----------------------------------------------------------------------------
// antenna_tuning_sweep
// LC antenna auto-tune: sweeps capacitor codes and keeps the closest count.
// ----------------------------------------------------------------------------
// The result of a tick transfer is registered. Throughput: one tick per
// cycle while in_ready is high; the sweep state updates in a single pass.
// A skid stage lets one more tick in while a result is held by out_ready.
// Reset (rst, synchronous): sweep idle, codes and counts zero, registers
// back to target 3125, settle 10000, window 100000, start limit 10000.
`default_nettype none

module antenna_tuning_sweep #(
  parameter int CAP_CODES = ats_pkg::CAP_CODES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ats_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ats_pkg::DATA_W-1:0]  pwdata,
  output logic      [ats_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  // tick channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        start_req,
  input  wire logic                        lco_edge,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [ats_pkg::CAP_W-1:0]   cap_drive,
  output logic                             show_oscillator,
  output logic                             busy_res,
  output logic                             done_res,
  output logic      [ats_pkg::CAP_W-1:0]   chosen_cap,
  output logic      [ats_pkg::EDGE_W-1:0]  last_edges
);
  import ats_pkg::*;

  ats_cfg_t    cfg;
  ats_result_t step_result;
  ats_result_t out_data;
  logic        tick_xfer;
  logic        buf_space;

  // Configuration registers, read straight by the sweep so that a new
  // value counts from the next compare on.
  ats_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the sweep by one tick on each tick transfer; the result
  // carries the state as it stands after that tick.
  assign in_ready  = buf_space;
  assign tick_xfer = in_valid & in_ready;

  ats_sweep #(
    .CAP_CODES (CAP_CODES)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .step      (tick_xfer),
    .start_req (start_req),
    .lco_edge  (lco_edge),
    .cfg       (cfg),
    .result    (step_result)
  );

  // Hold results in the output register, spill into the skid stage when
  // the consumer stalls, and stop taking ticks only when both are full.
  ats_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick_xfer),
    .push_data (step_result),
    .space     (buf_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign cap_drive       = out_data.cap_drive;
  assign show_oscillator = out_data.show_oscillator;
  assign busy_res        = out_data.busy_res;
  assign done_res        = out_data.done_res;
  assign chosen_cap      = out_data.chosen_cap;
  assign last_edges      = out_data.last_edges;

  // a finishing tick has already left the busy state
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done result still marked busy");

  // the skid stage fills only behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("tick channel stalled with no result held");

  // oscillator routing follows the run flag
  a_show_tracks_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> show_oscillator == busy_res)
    else $error("show_oscillator differs from busy_res");

  // a stalled tick channel frees up once a result is taken
  a_stall_clears: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("skid stage not drained after result transfer");

endmodule

`default_nettype wire
